>>> rtl/assert_macros.svh
// assertion macros for the palette block decoder rtl
// no dependencies; clk and rst_n are taken from the including module's scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// checked while out of reset
`define PBD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// checked on every edge, reset included
`define PBD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define PBD_ASSERT(lbl, prop, msg)
`define PBD_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

>>> rtl/pbd_pkg.sv
// shared types and constants of the palette block decoder
// no dependencies
package pbd_pkg;

  localparam int WORD_BITS    = 32;
  localparam int MAX_ENC_BITS = 16;
  localparam int DIM_BITS     = 5;
  localparam int CARRY_BITS   = 16;
  localparam int ACC_BITS     = 48;
  localparam int AVAIL_BITS   = 6;
  localparam int ADDR_BITS    = 32;
  localparam int LABEL_W      = 64;
  localparam int CFG_IDX_BITS = 3;
  localparam int CFG_DATA_W   = 32;
  localparam int OPA_BITS     = 17;

  typedef enum logic [1:0] {
    MODE_START   = 2'd0,
    MODE_PALETTE = 2'd1,
    MODE_WORD    = 2'd2
  } pbd_mode_t;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_STRIDE_X = 3'd0,
    CFG_STRIDE_Y = 3'd1,
    CFG_STRIDE_Z = 3'd2,
    CFG_DIM_X    = 3'd3,
    CFG_DIM_Y    = 3'd4,
    CFG_DIM_Z    = 3'd5
  } pbd_cfg_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_TOT_A,
    S_TOT_B,
    S_TOT_C,
    S_DIV_X,
    S_DIV_Y,
    S_M0,
    S_M1,
    S_M2,
    S_M3,
    S_M4,
    S_M5,
    S_RUN
  } pbd_state_t;

  typedef struct packed {
    logic [1:0]  mode;
    logic [4:0]  encoding_bits;
    logic [15:0] origin_x;
    logic [15:0] origin_y;
    logic [15:0] origin_z;
    logic [7:0]  entry_index;
    logic [63:0] entry_label;
    logic [31:0] packed_word;
  } pbd_in_t;

  typedef struct packed {
    logic [63:0] label;
    logic [31:0] out_address;
    logic        run_last;
    logic        block_done;
    logic        bad_width;
  } pbd_out_t;

  typedef struct packed {
    logic                load;
    logic                shift;
    logic [DIM_BITS-1:0] width;
  } pbd_unp_ctl_t;

endpackage

>>> rtl/pbd_palette_ram.sv
// palette label memory: one write port, one registered read port
// depends on nothing but its parameters
module pbd_palette_ram #(
  parameter int DEPTH  = 256,
  parameter int DATA_W = 64
) (
  input  logic                      clk,
  input  logic                      we,
  input  logic [$clog2(DEPTH)-1:0]  waddr,
  input  logic [DATA_W-1:0]         wdata,
  input  logic                      re,
  input  logic [$clog2(DEPTH)-1:0]  raddr,
  output logic [DATA_W-1:0]         rdata
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> rtl/pbd_div.sv
// restoring divider, one quotient bit per cycle, small divisor
// used to split the voxel position into x, y and z; needs only pbd_pkg
module pbd_div #(
  parameter int DW = 13
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [DW-1:0]                 dividend,
  input  logic [pbd_pkg::DIM_BITS-1:0]  divisor,
  output logic                          busy,
  output logic [DW-1:0]                 quo,
  output logic [pbd_pkg::DIM_BITS-1:0]  rem
);
  import pbd_pkg::*;

  localparam int CW = $clog2(DW + 1);

  logic [DW-1:0]       quo_r;
  logic [DIM_BITS-1:0] rem_r;
  logic [DIM_BITS-1:0] dvs_r;
  logic [CW-1:0]       cnt_r;
  logic                busy_r;
  logic [DIM_BITS:0]   trial;
  logic                ge;

  always_comb begin
    trial = {rem_r, quo_r[DW-1]};
    ge    = trial >= {1'b0, dvs_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= CW'(DW);
      quo_r  <= dividend;
      rem_r  <= '0;
      dvs_r  <= divisor;
    end else if (busy_r) begin
      rem_r  <= ge ? DIM_BITS'(trial - {1'b0, dvs_r}) : trial[DIM_BITS-1:0];
      quo_r  <= DW'({quo_r, ge});
      cnt_r  <= cnt_r - CW'(1);
      if (cnt_r == CW'(1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  assign busy = busy_r;
  assign quo  = quo_r;
  assign rem  = rem_r;

endmodule

>>> rtl/pbd_unpack.sv
// bit unpacker: holds carried bits plus the current word, peels one index a step
// uses pbd_pkg for widths and the control struct
module pbd_unpack (
  input  logic                                clk,
  input  logic                                rst_n,
  input  pbd_pkg::pbd_unp_ctl_t               ctl,
  input  logic [pbd_pkg::CARRY_BITS-1:0]      carry_in,
  input  logic [pbd_pkg::DIM_BITS-1:0]        carry_cnt,
  input  logic [pbd_pkg::WORD_BITS-1:0]       word,
  output logic [pbd_pkg::MAX_ENC_BITS-1:0]    slot,
  output logic [pbd_pkg::AVAIL_BITS-1:0]      avail,
  output logic [pbd_pkg::CARRY_BITS-1:0]      rest
);
  import pbd_pkg::*;

  logic [ACC_BITS-1:0]     acc_r;
  logic [AVAIL_BITS-1:0]   avail_r;
  logic [MAX_ENC_BITS:0]   mask_w;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r   <= '0;
      avail_r <= '0;
    end else if (ctl.load) begin
      acc_r   <= ACC_BITS'(carry_in) | (ACC_BITS'(word) << carry_cnt);
      avail_r <= AVAIL_BITS'(carry_cnt) + AVAIL_BITS'(WORD_BITS);
    end else if (ctl.shift) begin
      acc_r   <= acc_r >> ctl.width;
      avail_r <= avail_r - AVAIL_BITS'(ctl.width);
    end
  end

  // low index bits under the current width
  always_comb begin
    mask_w = ((MAX_ENC_BITS+1)'(1) << ctl.width) - (MAX_ENC_BITS+1)'(1);
    slot   = acc_r[MAX_ENC_BITS-1:0] & mask_w[MAX_ENC_BITS-1:0];
  end

  assign avail = avail_r;
  assign rest  = acc_r[CARRY_BITS-1:0];

endmodule

>>> rtl/palette_bitstream_block_decoder.sv
// top level of the palette block decoder: sequencer, shared multiplier, address walk
// uses pbd_pkg, pbd_palette_ram, pbd_div, pbd_unpack and assert_macros.svh
//
// Expands one palette-compressed label block into voxel labels with their
// strided output addresses. A start beat (mode 0) sets the index width and
// the block origin; a width above 16 or one whose palette would exceed
// PALETTE_DEPTH gives a single bad_width result and leaves the block idle.
// Palette beats (mode 1) write a label into a slot; slots never written read
// back as garbage. Word beats (mode 2) each produce the voxels whose indices
// they complete, x fastest, at most 32, one result per cycle while the output
// is not stalled; leftover index bits carry into the next word. The first
// word after a start, or after any register write, first runs a setup pass
// on the shared 17x32 multiplier and the bit-serial divider that rebuilds
// the block size, the x/y/z position and the address walkers. Register
// writes must only happen while the block idles.
module palette_bitstream_block_decoder #(
  parameter int PALETTE_DEPTH  = 256,
  parameter int LABEL_BITS     = 64,
  parameter int MAX_BLOCK_EDGE = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // input channel
  input  logic                               in_valid,
  output logic                               in_stall,
  input  pbd_pkg::pbd_in_t                   in_data,
  // result channel
  output logic                               out_valid,
  input  logic                               out_stall,
  output pbd_pkg::pbd_out_t                  out_data,
  // register write port
  input  logic                               cfg_we,
  input  logic [pbd_pkg::CFG_IDX_BITS-1:0]   cfg_index,
  input  logic [pbd_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
  import pbd_pkg::*;

  // only 256 slots can ever be written, so the memory never needs more
  localparam int MEM_DEPTH = (PALETTE_DEPTH < 256) ? PALETTE_DEPTH : 256;
  localparam int MEM_AW    = $clog2(MEM_DEPTH);
  // dimension registers are 5 bits, so an edge never exceeds 31
  localparam int EDGE_CAP  = (MAX_BLOCK_EDGE < 31) ? MAX_BLOCK_EDGE : 31;
  localparam int POS_W     = $clog2(EDGE_CAP * EDGE_CAP * EDGE_CAP + 1);
  localparam int PW1       = POS_W + 1;

  // configuration registers
  logic [ADDR_BITS-1:0] stride_x_r, stride_y_r, stride_z_r;
  logic [DIM_BITS-1:0]  dim_x_r, dim_y_r, dim_z_r;

  // block state
  pbd_state_t           state_r, state_nxt;
  logic [DIM_BITS-1:0]  width_r;
  logic [15:0]          org_x_r, org_y_r, org_z_r;
  logic [POS_W-1:0]     pos_r;
  logic [POS_W-1:0]     total_r;
  logic [CARRY_BITS-1:0] carry_bits_r;
  logic [DIM_BITS-1:0]  carry_cnt_r;
  logic                 active_r;
  logic                 dirty_r;      // position/address walkers need a rebuild
  logic [AVAIL_BITS-1:0] n_r;         // voxels issued for the current word

  // address walkers: current voxel, start of its row, start of its plane
  logic [DIM_BITS-1:0]  x_r, y_r, z_r;
  logic [ADDR_BITS-1:0] addr_r, row_r, plane_r;

  // shared multiplier
  logic [OPA_BITS-1:0]  mul_a;
  logic [ADDR_BITS-1:0] mul_b;
  logic [ADDR_BITS-1:0] prod_r;

  // pending stage (waits on the palette read) and output register
  logic                 p_valid_r;
  logic [ADDR_BITS-1:0] p_addr_r;
  logic                 p_last_r, p_done_r, p_bad_r;
  logic                 out_valid_r;
  pbd_out_t             out_data_r;

  // live block edges
  logic [DIM_BITS-1:0]  edge_x, edge_y, edge_z;

  // handshake and control
  logic                 in_fire, p_move, p_free;
  logic                 start_bad, w0, more_bits, next_bits;
  logic                 cont, cont_next, issue, finish, push_bad;
  logic                 div_start, div_busy;
  logic [POS_W-1:0]     div_dividend, div_quo;
  logic [DIM_BITS-1:0]  div_divisor, div_rem;
  pbd_unp_ctl_t         unp_ctl;
  logic [MAX_ENC_BITS-1:0] unp_slot;
  logic [AVAIL_BITS-1:0] unp_avail;
  logic [CARRY_BITS-1:0] unp_rest;
  logic                 ram_we;
  logic [MEM_AW-1:0]    ram_raddr;
  logic [LABEL_BITS-1:0] ram_rdata;

  function automatic logic [DIM_BITS-1:0] clamp_edge(input logic [DIM_BITS-1:0] d);
    logic [DIM_BITS-1:0] e;
    if (d == '0) begin
      e = DIM_BITS'(1);
    end else if (32'(d) > MAX_BLOCK_EDGE) begin
      e = DIM_BITS'(EDGE_CAP);
    end else begin
      e = d;
    end
    return e;
  endfunction

  assign edge_x = clamp_edge(dim_x_r);
  assign edge_y = clamp_edge(dim_y_r);
  assign edge_z = clamp_edge(dim_z_r);

  // handshake
  assign in_stall = (state_r != S_IDLE) || p_valid_r;
  assign in_fire  = in_valid && !in_stall;
  assign p_move   = p_valid_r && (!out_valid_r || !out_stall);
  assign p_free   = !p_valid_r || p_move;

  // start width check: too wide, or more entries than the palette holds
  assign start_bad = (in_data.encoding_bits > DIM_BITS'(MAX_ENC_BITS)) ||
                     ((32'd1 << in_data.encoding_bits) > 32'(PALETTE_DEPTH));

  // ---------------------------------------------------------------------------
  // next state
  // ---------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire && (in_data.mode == MODE_WORD) && active_r) begin
          state_nxt = dirty_r ? S_TOT_A : S_RUN;
        end
      end
      S_TOT_A: state_nxt = S_TOT_B;
      S_TOT_B: state_nxt = S_TOT_C;
      S_TOT_C: state_nxt = S_DIV_X;
      S_DIV_X: begin
        if (!div_busy) begin
          state_nxt = S_DIV_Y;
        end
      end
      S_DIV_Y: begin
        if (!div_busy) begin
          state_nxt = S_M0;
        end
      end
      S_M0:    state_nxt = S_M1;
      S_M1:    state_nxt = S_M2;
      S_M2:    state_nxt = S_M3;
      S_M3:    state_nxt = S_M4;
      S_M4:    state_nxt = S_M5;
      S_M5:    state_nxt = S_RUN;
      S_RUN: begin
        if (!cont) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------------
  // sequencer outputs
  // ---------------------------------------------------------------------------
  always_comb begin
    w0        = (width_r == '0);
    more_bits = w0 || (unp_avail >= AVAIL_BITS'(width_r));
    cont      = (n_r < AVAIL_BITS'(WORD_BITS)) && (pos_r < total_r) && more_bits;
    // would the voxel after this one still come from the same word
    next_bits = w0 || ((unp_avail - AVAIL_BITS'(width_r)) >= AVAIL_BITS'(width_r));
    cont_next = ((n_r + AVAIL_BITS'(1)) < AVAIL_BITS'(WORD_BITS)) &&
                ((PW1'(pos_r) + PW1'(1)) < PW1'(total_r)) && next_bits;

    issue        = 1'b0;
    finish       = 1'b0;
    div_start    = 1'b0;
    div_dividend = pos_r;
    div_divisor  = edge_x;
    mul_a        = '0;
    mul_b        = '0;
    unp_ctl      = '{load: 1'b0, shift: 1'b0, width: width_r};

    unique case (state_r)
      S_IDLE: begin
        unp_ctl.load = in_fire && (in_data.mode == MODE_WORD);
      end
      S_TOT_A: begin
        mul_a = OPA_BITS'(edge_x);
        mul_b = ADDR_BITS'(edge_y);
      end
      S_TOT_B: begin
        mul_a = prod_r[OPA_BITS-1:0];
        mul_b = ADDR_BITS'(edge_z);
      end
      S_TOT_C: begin
        div_start = 1'b1;
      end
      S_DIV_X: begin
        div_dividend = div_quo;
        div_divisor  = edge_y;
        div_start    = !div_busy;
      end
      S_DIV_Y: ;
      S_M0: begin
        mul_a = OPA_BITS'(org_x_r) + OPA_BITS'(x_r);
        mul_b = stride_x_r;
      end
      S_M1: begin
        mul_a = OPA_BITS'(org_x_r);
        mul_b = stride_x_r;
      end
      S_M2: begin
        mul_a = OPA_BITS'(org_y_r) + OPA_BITS'(y_r);
        mul_b = stride_y_r;
      end
      S_M3: begin
        mul_a = OPA_BITS'(org_y_r);
        mul_b = stride_y_r;
      end
      S_M4: begin
        mul_a = OPA_BITS'(org_z_r) + OPA_BITS'(z_r);
        mul_b = stride_z_r;
      end
      S_M5: ;
      S_RUN: begin
        issue         = cont && p_free;
        finish        = !cont;
        unp_ctl.shift = issue && !w0;
      end
      default: ;
    endcase
  end

  assign push_bad  = in_fire && (in_data.mode == MODE_START) && start_bad;
  assign ram_we    = in_fire && (in_data.mode == MODE_PALETTE) &&
                     (32'(in_data.entry_index) < 32'(PALETTE_DEPTH));
  assign ram_raddr = w0 ? '0 : unp_slot[MEM_AW-1:0];

  // ---------------------------------------------------------------------------
  // state and registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // register writes; any write forces a rebuild before the next word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stride_x_r <= ADDR_BITS'(1);
      stride_y_r <= ADDR_BITS'(64);
      stride_z_r <= ADDR_BITS'(4096);
      dim_x_r    <= DIM_BITS'(8);
      dim_y_r    <= DIM_BITS'(8);
      dim_z_r    <= DIM_BITS'(8);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_STRIDE_X: stride_x_r <= cfg_wdata;
        CFG_STRIDE_Y: stride_y_r <= cfg_wdata;
        CFG_STRIDE_Z: stride_z_r <= cfg_wdata;
        CFG_DIM_X:    dim_x_r    <= cfg_wdata[DIM_BITS-1:0];
        CFG_DIM_Y:    dim_y_r    <= cfg_wdata[DIM_BITS-1:0];
        CFG_DIM_Z:    dim_z_r    <= cfg_wdata[DIM_BITS-1:0];
        default: ;
      endcase
    end
  end

  // shared multiplier, product registered
  always_ff @(posedge clk) begin
    prod_r <= ADDR_BITS'(mul_a * mul_b);
  end

  // block control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r      <= '0;
      org_x_r      <= '0;
      org_y_r      <= '0;
      org_z_r      <= '0;
      pos_r        <= '0;
      total_r      <= '0;
      carry_bits_r <= '0;
      carry_cnt_r  <= '0;
      active_r     <= 1'b0;
      dirty_r      <= 1'b1;
      n_r          <= '0;
    end else begin
      if (cfg_we) begin
        dirty_r <= 1'b1;
      end
      if (in_fire && (in_data.mode == MODE_START)) begin
        width_r      <= in_data.encoding_bits;
        org_x_r      <= in_data.origin_x;
        org_y_r      <= in_data.origin_y;
        org_z_r      <= in_data.origin_z;
        pos_r        <= '0;
        carry_bits_r <= '0;
        carry_cnt_r  <= '0;
        active_r     <= !start_bad;
        dirty_r      <= 1'b1;
      end
      if (in_fire && (in_data.mode == MODE_WORD)) begin
        n_r <= '0;
      end
      if (state_r == S_TOT_C) begin
        total_r <= prod_r[POS_W-1:0];
      end
      if (state_r == S_M5) begin
        dirty_r <= 1'b0;
      end
      if (issue) begin
        pos_r <= pos_r + POS_W'(1);
        n_r   <= n_r + AVAIL_BITS'(1);
      end
      if (finish) begin
        if (!w0) begin
          carry_bits_r <= unp_rest;
          carry_cnt_r  <= (unp_avail > AVAIL_BITS'(CARRY_BITS)) ?
                          DIM_BITS'(CARRY_BITS) : unp_avail[DIM_BITS-1:0];
        end
        // block end drops whatever is left of the word
        if (pos_r >= total_r) begin
          active_r     <= 1'b0;
          carry_bits_r <= '0;
          carry_cnt_r  <= '0;
        end
      end
    end
  end

  // address walkers: rebuilt in setup, stepped by one add per voxel
  always_ff @(posedge clk) begin
    if (state_r == S_DIV_X && !div_busy) begin
      x_r <= div_rem;
    end
    if (state_r == S_DIV_Y && !div_busy) begin
      y_r <= div_rem;
      z_r <= div_quo[DIM_BITS-1:0];
    end
    unique case (state_r)
      S_M1: addr_r <= prod_r;
      S_M2: begin
        row_r   <= prod_r;
        plane_r <= prod_r;
      end
      S_M3: begin
        addr_r <= addr_r + prod_r;
        row_r  <= row_r + prod_r;
      end
      S_M4: plane_r <= plane_r + prod_r;
      S_M5: begin
        addr_r  <= addr_r + prod_r;
        row_r   <= row_r + prod_r;
        plane_r <= plane_r + prod_r;
      end
      default: ;
    endcase
    if (issue) begin
      if (({1'b0, x_r} + (DIM_BITS+1)'(1)) < {1'b0, edge_x}) begin
        x_r    <= x_r + DIM_BITS'(1);
        addr_r <= addr_r + stride_x_r;
      end else begin
        x_r <= '0;
        if (({1'b0, y_r} + (DIM_BITS+1)'(1)) < {1'b0, edge_y}) begin
          y_r    <= y_r + DIM_BITS'(1);
          row_r  <= row_r + stride_y_r;
          addr_r <= row_r + stride_y_r;
        end else begin
          y_r     <= '0;
          z_r     <= z_r + DIM_BITS'(1);
          plane_r <= plane_r + stride_z_r;
          row_r   <= plane_r + stride_z_r;
          addr_r  <= plane_r + stride_z_r;
        end
      end
    end
  end

  // pending stage: one voxel waiting on its palette read, or the error beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_valid_r <= 1'b0;
    end else if (issue || push_bad) begin
      p_valid_r <= 1'b1;
    end else if (p_move) begin
      p_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      p_addr_r <= addr_r;
      p_last_r <= !cont_next;
      p_done_r <= (PW1'(pos_r) + PW1'(1)) >= PW1'(total_r);
      p_bad_r  <= 1'b0;
    end else if (push_bad) begin
      p_addr_r <= '0;
      p_last_r <= 1'b1;
      p_done_r <= 1'b0;
      p_bad_r  <= 1'b1;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (p_move) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (p_move) begin
      out_data_r.label       <= p_bad_r ? '0 : LABEL_W'(ram_rdata);
      out_data_r.out_address <= p_addr_r;
      out_data_r.run_last    <= p_last_r;
      out_data_r.block_done  <= p_done_r;
      out_data_r.bad_width   <= p_bad_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // ---------------------------------------------------------------------------
  // units
  // ---------------------------------------------------------------------------
  pbd_palette_ram #(
    .DEPTH  (MEM_DEPTH),
    .DATA_W (LABEL_BITS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (in_data.entry_index[MEM_AW-1:0]),
    .wdata (in_data.entry_label[LABEL_BITS-1:0]),
    .re    (issue),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  pbd_div #(
    .DW (POS_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .busy     (div_busy),
    .quo      (div_quo),
    .rem      (div_rem)
  );

  pbd_unpack u_unpack (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (unp_ctl),
    .carry_in  (carry_bits_r),
    .carry_cnt (carry_cnt_r),
    .word      (in_data.packed_word),
    .slot      (unp_slot),
    .avail     (unp_avail),
    .rest      (unp_rest)
  );

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
`include "assert_macros.svh"

  `PBD_ASSERT(a_done_is_last, out_valid && out_data.block_done |-> out_data.run_last, "block end not last of word")
  `PBD_ASSERT(a_bad_beat, out_valid && out_data.bad_width |-> (out_data.label == '0) && !out_data.block_done, "error beat carries voxel data")
  `PBD_ASSERT(a_index_bits, issue && (width_r != '0) |-> unp_avail >= AVAIL_BITS'(width_r), "index taken from incomplete bits")
  `PBD_ASSERT(a_word_cap, state_r == S_RUN |-> n_r <= AVAIL_BITS'(WORD_BITS), "more voxels than a word holds")
  `PBD_ASSERT_ALWAYS(a_reset_idle, !rst_n |=> (state_r == S_IDLE) && !out_valid && !p_valid_r, "not idle after reset")

endmodule
